### rtl/enms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enms_pkg: shared types and constants for edge non-maximum suppression
// Field widths of the pixel and result words, register indices, defaults.
// ----------------------------------------------------------------------------
package enms_pkg;

	localparam int GRAD_W = 11;
	localparam int MAG_W  = 11;
	localparam int ROW_W  = 12;
	localparam int COL_W  = 10;
	localparam int DIM_W  = 13;
	localparam int FW_W   = 11;
	localparam int FH_W   = 13;
	localparam int CFG_DATA_W = 13;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAG_BITS_DEF  = 11;
	localparam int MAX_HEIGHT    = 4096;
	localparam int MIN_DIM       = 3;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	// tangent thresholds scaled by 256
	localparam int TAN_SCALE_SH = 8;
	localparam int TAN_LO       = 106;
	localparam int TAN_HI       = 618;

	typedef enum logic [0:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		SEC_HORZ = 2'd0,
		SEC_DIAG = 2'd1,
		SEC_VERT = 2'd2,
		SEC_ANTI = 2'd3
	} sector_t;

endpackage
`default_nettype wire

### rtl/enms_pix_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enms_pix_if: pixel channel
// One word per pixel: frame start mark, gradients and magnitude.
// ----------------------------------------------------------------------------
interface enms_pix_if;
	logic                                valid;
	logic                                ready;
	logic                                start_of_frame;
	logic signed [enms_pkg::GRAD_W-1:0]  grad_x;
	logic signed [enms_pkg::GRAD_W-1:0]  grad_y;
	logic        [enms_pkg::MAG_W-1:0]   magnitude;

	modport source (
		output valid, start_of_frame, grad_x, grad_y, magnitude,
		input  ready
	);
	modport sink (
		input  valid, start_of_frame, grad_x, grad_y, magnitude,
		output ready
	);
endinterface
`default_nettype wire

### rtl/enms_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enms_res_if: result channel
// One word per pixel taken: centre flag, kept magnitude and its position.
// ----------------------------------------------------------------------------
interface enms_res_if;
	logic                               valid;
	logic                               ready;
	logic                               out_valid;
	logic [enms_pkg::MAG_W-1:0]         out_value;
	logic [enms_pkg::ROW_W-1:0]         out_row;
	logic [enms_pkg::COL_W-1:0]         out_col;

	modport source (
		output valid, out_valid, out_value, out_row, out_col,
		input  ready
	);
	modport sink (
		input  valid, out_valid, out_value, out_row, out_col,
		output ready
	);
endinterface
`default_nettype wire

### rtl/enms_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enms_ram: simple dual-port RAM
// One write and one registered read per cycle; a read at the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module enms_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/edge_nonmax_suppression.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edge_nonmax_suppression: four-sector non-maximum suppression of a pixel stream
// Thins gradient edges: each pixel keeps its magnitude only where it beats both
// neighbours along its quantised gradient direction.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless held and gives one result word per pixel,
// which reports the pixel one row up and one column left (out_valid low while
// there is no such pixel). A pixel's result passes through stage 1 and the
// output register before it is offered. While a result waits the input takes
// one more pixel and then holds; with the result side ready a pixel is taken
// every cycle, so the sustained rate is one pixel per cycle; it is set by the
// line store, a single RAM holding both magnitude lines and the sector line,
// read once and written once per pixel. After reset the line store is cleared
// one entry a cycle, all MAX_WIDTH of them, taking register writes but no pixel.
// ----------------------------------------------------------------------------
module edge_nonmax_suppression #(
	parameter int MAX_WIDTH = enms_pkg::MAX_WIDTH_DEF,
	parameter int MAG_BITS  = enms_pkg::MAG_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	enms_pix_if.sink                               pix,
	enms_res_if.source                             res,
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_index,
	input  wire logic [enms_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int RAM_W = 2 * MAG_BITS + 2;
	localparam int DW    = enms_pkg::DIM_W;
	localparam int RW    = enms_pkg::ROW_W;
	localparam int PW    = 2 * enms_pkg::GRAD_W - 1;

	// registers
	logic [enms_pkg::FW_W-1:0] width_q;
	logic [enms_pkg::FH_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= enms_pkg::FRAME_WIDTH_RST;
			height_q <= enms_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (enms_pkg::cfg_index_t'(cfg_index))
				enms_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_data[enms_pkg::FW_W-1:0];
				enms_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_data[enms_pkg::FH_W-1:0];
			endcase
		end
	end

	logic [DW-1:0] eff_w, eff_h;

	always_comb begin
		eff_w = DW'(width_q);
		if (eff_w < DW'(enms_pkg::MIN_DIM)) eff_w = DW'(enms_pkg::MIN_DIM);
		if (eff_w > DW'(MAX_WIDTH)) eff_w = DW'(MAX_WIDTH);
		eff_h = DW'(height_q);
		if (eff_h < DW'(enms_pkg::MIN_DIM)) eff_h = DW'(enms_pkg::MIN_DIM);
		if (eff_h > DW'(enms_pkg::MAX_HEIGHT)) eff_h = DW'(enms_pkg::MAX_HEIGHT);
	end

	// clearing pass over the line store
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(MAX_WIDTH - 1)) clr_busy_q <= 1'b0;
		end
	end

	// handshake
	logic vld_s1, ovld_q;
	logic s1_move, accept;

	assign s1_move   = vld_s1 && (!ovld_q || res.ready);
	assign pix.ready = !clr_busy_q && (!vld_s1 || s1_move);
	assign accept    = pix.valid && pix.ready;

	// position counters
	logic [RW-1:0] row_q, row_cur;
	logic [AW-1:0] col_q, col_cur;
	logic [DW-1:0] col_inc, row_inc;
	logic [RW-1:0] row_nxt;
	logic [AW-1:0] col_nxt;

	always_comb begin
		row_cur = pix.start_of_frame ? '0 : row_q;
		col_cur = pix.start_of_frame ? '0 : col_q;
		col_inc = DW'(col_cur) + 1'b1;
		row_inc = DW'(row_cur);
		col_nxt = AW'(col_inc);
		if (col_inc >= eff_w) begin
			col_nxt = '0;
			row_inc = DW'(row_cur) + 1'b1;
			if (row_inc >= eff_h) row_inc = '0;
		end
		if (row_inc >= eff_h) row_inc = '0;
		row_nxt = RW'(row_inc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			row_q <= row_nxt;
			col_q <= col_nxt;
		end
	end

	// direction sector from tangent comparisons
	logic [enms_pkg::GRAD_W-1:0] abs_x, abs_y;
	logic [PW-1:0]               ay_sc, ax_lo, ax_hi;
	enms_pkg::sector_t           sec_in;

	always_comb begin
		abs_x = pix.grad_x[enms_pkg::GRAD_W-1] ? enms_pkg::GRAD_W'(-pix.grad_x)
			: enms_pkg::GRAD_W'(pix.grad_x);
		abs_y = pix.grad_y[enms_pkg::GRAD_W-1] ? enms_pkg::GRAD_W'(-pix.grad_y)
			: enms_pkg::GRAD_W'(pix.grad_y);
		ay_sc = PW'(abs_y) << enms_pkg::TAN_SCALE_SH;
		ax_lo = PW'(abs_x) * PW'(enms_pkg::TAN_LO);
		ax_hi = PW'(abs_x) * PW'(enms_pkg::TAN_HI);
		priority if (ay_sc <= ax_lo) begin
			sec_in = enms_pkg::SEC_HORZ;
		end else if (ay_sc > ax_hi) begin
			sec_in = enms_pkg::SEC_VERT;
		end else if (pix.grad_x[enms_pkg::GRAD_W-1] == pix.grad_y[enms_pkg::GRAD_W-1]) begin
			sec_in = enms_pkg::SEC_DIAG;
		end else begin
			sec_in = enms_pkg::SEC_ANTI;
		end
	end

	// stage 1: line store read in flight
	logic [RW-1:0]       row_s1;
	logic [AW-1:0]       col_s1;
	enms_pkg::sector_t   sec_s1;
	logic [MAG_BITS-1:0] bot_s1;
	logic                fwd_s1;
	logic [RAM_W-1:0]    fwd_word_s1;
	logic [RAM_W-1:0]    wr_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
			// same entry written at this edge: ram gives the old word
			fwd_s1 <= s1_move && (col_s1 == col_cur);
		end else if (s1_move) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1      <= row_cur;
			col_s1      <= col_cur;
			sec_s1      <= sec_in;
			bot_s1      <= MAG_BITS'(pix.magnitude);
			fwd_word_s1 <= wr_word;
		end
	end

	// line store: {previous row, older row, previous row sector}
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [RAM_W-1:0] ram_wdata, ram_rdata, line_word;

	enms_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (col_cur),
		.rdata (ram_rdata)
	);

	logic [MAG_BITS-1:0] top, mid, lo, hi, result;
	enms_pkg::sector_t   line_sec;

	assign line_word = fwd_s1 ? fwd_word_s1 : ram_rdata;
	assign line_sec  = enms_pkg::sector_t'(line_word[1:0]);
	assign top       = line_word[MAG_BITS+1:2];
	assign mid       = line_word[RAM_W-1:MAG_BITS+2];
	assign wr_word   = {bot_s1, mid, 2'(sec_s1)};

	always_comb begin
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = s1_move;
			ram_waddr = col_s1;
			ram_wdata = wr_word;
		end
	end

	// 3x3 window: left column in 0..2, middle column in 3..5, top to bottom
	logic [MAG_BITS-1:0] win_q [6];
	enms_pkg::sector_t   centre_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
			centre_q <= enms_pkg::SEC_HORZ;
		end else if (s1_move) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= bot_s1;
			centre_q <= line_sec;
		end
	end

	logic          centre_ok, inner;
	logic [AW-1:0] col_m1;

	always_comb begin
		unique case (centre_q)
			enms_pkg::SEC_HORZ: begin lo = win_q[1]; hi = mid;      end
			enms_pkg::SEC_DIAG: begin lo = win_q[0]; hi = bot_s1;   end
			enms_pkg::SEC_VERT: begin lo = win_q[3]; hi = win_q[5]; end
			enms_pkg::SEC_ANTI: begin lo = top;      hi = win_q[2]; end
		endcase
		centre_ok = (row_s1 != '0) && (col_s1 != '0);
		inner     = (row_s1 > RW'(1)) && (col_s1 > AW'(1));
		result    = (inner && win_q[4] > lo && win_q[4] > hi) ? win_q[4] : '0;
		col_m1    = col_s1 - 1'b1;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (s1_move) begin
			ovld_q <= 1'b1;
		end else if (res.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			res.out_valid <= centre_ok;
			res.out_value <= centre_ok ? enms_pkg::MAG_W'(result) : '0;
			res.out_row   <= centre_ok ? row_s1 - 1'b1 : '0;
			res.out_col   <= centre_ok ? enms_pkg::COL_W'(col_m1) : '0;
		end
	end

	assign res.valid = ovld_q;

	// checks
	a_fwd_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> vld_s1)
		else $error("forward flag without a word in stage 1");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> vld_s1)
		else $error("accepted word missing from stage 1");

	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !pix.ready && !vld_s1 && !ovld_q)
		else $error("pixel traffic during line store clear");

	a_move_writes: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |-> ram_we && ram_waddr == col_s1)
		else $error("stage 1 left without line store write");

endmodule
`default_nettype wire
